// ===== sv/levd_pkg.sv =====
// levd_pkg: shared widths, command codes and sequencer state type
// for the levenshtein edit distance engine; no dependencies
package levd_pkg;

   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int DIST_W = 7;

   localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd2;

   localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INIT    = 6'b000010,
      ST_ROW     = 6'b000100,
      ST_CELL_RD = 6'b001000,
      ST_CELL_WR = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

endpackage

// ===== sv/levd_if.sv =====
// levd_req_if and levd_rsp_if: valid/ready channels for load/compute items
// and distance results; depends on levd_pkg
interface levd_req_if;
   import levd_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [CHAR_W-1:0] char_byte;

   modport source (output valid, output cmd, output char_byte, input ready);
   modport sink   (input valid, input cmd, input char_byte, output ready);
endinterface

interface levd_rsp_if;
   import levd_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              overflow;

   modport source (output valid, output distance, output overflow, input ready);
   modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// ===== sv/edit_distance_levenshtein_top.sv =====
// edit_distance_levenshtein_top: string loader and iterative levenshtein sweep
// depends on levd_pkg and the channel interfaces in levd_if.sv
//
// Append items (cmd 0 to the first string, cmd 1 to the second) are accepted
// back to back. A compute item (cmd 2) makes the block busy for a sweep:
// one row-initialisation pass, then per row one setup state and, per cell,
// a read state and a write state through a single shared min-of-three unit
// behind the registered read of the row memory, then a hand-over state for
// the result. If either string is empty the block goes straight to the
// hand-over. The hand-over stretches while an earlier result still waits
// unread. A finished result waits in an output register, so new appends are
// taken while it is pending.
// Characters beyond MAX_LEN are dropped and flagged as overflow.
module edit_distance_levenshtein_top #(
   parameter int MAX_LEN = 64
) (
   input logic         clock,
   input logic         reset,
   levd_req_if.sink    req_ch,
   levd_rsp_if.source  rsp_ch
);
   import levd_pkg::*;

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int EXT_W = (LEN_W > DIST_W) ? LEN_W : DIST_W;

   logic [CHAR_W-1:0] first_mem  [MAX_LEN];
   logic [CHAR_W-1:0] second_mem [MAX_LEN];
   logic [LEN_W-1:0]  row_mem    [MAX_LEN+1];

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len1_ff, len1_in;
   logic [LEN_W-1:0]  len2_ff, len2_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  i_ff, i_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  diag_ff, diag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [CHAR_W-1:0] first_q_ff;
   logic [CHAR_W-1:0] second_q_ff;
   logic [LEN_W-1:0]  above_ff;

   logic              wr1_en, wr2_en, row_wr_en;
   logic [LEN_W-1:0]  row_wr_addr, row_wr_data, row_rd_addr;
   logic [LEN_W-1:0]  i_next, j_next;
   logic [LEN_W:0]    cand_left, cand_above, cand_diag, cell_min;
   logic [EXT_W-1:0]  dist_ext;
   logic [DIST_W-1:0] dist_sat;
   logic              req_fire;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign req_fire        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_dist_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

   assign i_next      = i_ff + LEN_W'(1);
   assign j_next      = j_ff + LEN_W'(1);
   assign row_rd_addr = j_next;

   // shared min-of-three unit
   always_comb begin
      cand_left  = {1'b0, left_ff} + (LEN_W+1)'(1);
      cand_above = {1'b0, above_ff} + (LEN_W+1)'(1);
      cand_diag  = {1'b0, diag_ff} + (LEN_W+1)'(first_q_ff != second_q_ff);
      cell_min   = cand_left;
      if (cand_above < cell_min) begin
         cell_min = cand_above;
      end
      if (cand_diag < cell_min) begin
         cell_min = cand_diag;
      end
   end

   assign dist_ext = EXT_W'(left_ff);
   assign dist_sat = (dist_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];

   always_comb begin
      state_in     = state_ff;
      len1_in      = len1_ff;
      len2_in      = len2_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr1_en       = 1'b0;
      wr2_en       = 1'b0;
      row_wr_en    = 1'b0;
      row_wr_addr  = j_ff;
      row_wr_data  = j_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.cmd)
                  CMD_APPEND_FIRST: begin
                     if (len1_ff < LEN_W'(MAX_LEN)) begin
                        wr1_en  = 1'b1;
                        len1_in = len1_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_APPEND_SECOND: begin
                     if (len2_ff < LEN_W'(MAX_LEN)) begin
                        wr2_en  = 1'b1;
                        len2_in = len2_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_COMPUTE: begin
                     if (len1_ff == '0 || len2_ff == '0) begin
                        // one string empty: distance is the other length
                        left_in  = len1_ff | len2_ff;
                        state_in = ST_DONE;
                     end else begin
                        j_in     = LEN_W'(1);
                        state_in = ST_INIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            row_wr_en = 1'b1;
            if (j_ff == len2_ff) begin
               i_in     = '0;
               state_in = ST_ROW;
            end else begin
               j_in = j_next;
            end
         end
         ST_ROW: begin
            // column zero of row i holds i, so it lives in the counter
            diag_in  = i_ff;
            left_in  = i_next;
            j_in     = '0;
            state_in = ST_CELL_RD;
         end
         ST_CELL_RD: begin
            state_in = ST_CELL_WR;
         end
         ST_CELL_WR: begin
            row_wr_en   = 1'b1;
            row_wr_addr = j_next;
            row_wr_data = cell_min[LEN_W-1:0];
            left_in     = cell_min[LEN_W-1:0];
            diag_in     = above_ff;
            if (j_next == len2_ff) begin
               if (i_next == len1_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_next;
                  state_in = ST_ROW;
               end
            end else begin
               j_in     = j_next;
               state_in = ST_CELL_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = dist_sat;
               rsp_ovf_in   = ovf_ff;
               len1_in      = '0;
               len2_in      = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len1_ff      <= '0;
         len2_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len1_ff      <= len1_in;
         len2_ff      <= len2_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // string stores
   always_ff @(posedge clock) begin
      if (wr1_en) begin
         first_mem[len1_ff[IDX_W-1:0]] <= req_ch.char_byte;
      end
      if (wr2_en) begin
         second_mem[len2_ff[IDX_W-1:0]] <= req_ch.char_byte;
      end
      first_q_ff  <= first_mem[i_ff[IDX_W-1:0]];
      second_q_ff <= second_mem[j_ff[IDX_W-1:0]];
   end

   // dynamic-programming row
   always_ff @(posedge clock) begin
      if (row_wr_en) begin
         row_mem[row_wr_addr] <= row_wr_data;
      end
      above_ff <= row_mem[row_rd_addr];
   end

endmodule

// ===== sv/levd_check.sv =====
// levd_check: port-level checks on the edit distance engine's channels
// bound to edit_distance_levenshtein_top; depends on levd_pkg
module levd_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [levd_pkg::CMD_W-1:0]    req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [levd_pkg::DIST_W-1:0]   rsp_distance,
   input logic                          rsp_overflow
);
   import levd_pkg::*;

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance) && $stable(rsp_overflow))
      else $error("result changed while stalled");

   // a compute item makes the block busy
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_COMPUTE |=> !req_ready)
      else $error("ready after compute item");

   // append and unused items keep the block ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_COMPUTE |=> req_ready)
      else $error("not ready after load item");

   // a new result only appears at the end of a busy sweep
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without a sweep");

endmodule

bind edit_distance_levenshtein_top levd_check u_levd_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_cmd      (req_ch.cmd),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_distance (rsp_ch.distance),
   .rsp_overflow (rsp_ch.overflow)
);
